// ===== rtl/core/rlapd_pkg.sv =====
// rlapd_pkg: shared types and constants for the rla plane decoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package rlapd_pkg;

  // parse phase of the packet decoder
  typedef enum logic [1:0] {
    PH_COUNT   = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2,
    PH_DROP    = 2'd3
  } phase_t;

  // configuration register indexes
  localparam logic [1:0] REG_PIXELS_PER_LINE    = 2'd0;
  localparam logic [1:0] REG_CHANNEL_COUNT      = 2'd1;
  localparam logic [1:0] REG_BYTES_PER_SAMPLE   = 2'd2;
  localparam logic [1:0] REG_HOST_LITTLE_ENDIAN = 2'd3;

  localparam int CFG_DATA_W = 14;
  localparam int POS_W      = 14;
  localparam int OFFSET_W   = 19;
  localparam int STRIDE_W   = 7;   // channels times bytes, up to 64

  // configuration values, already saturated to their legal ranges
  typedef struct packed {
    logic [POS_W-1:0]    pixels_per_line;
    logic [2:0]          bytes_per_sample;
    logic                host_little_endian;
    logic [STRIDE_W-1:0] stride;
  } cfg_t;

  // one decoded result beat
  typedef struct packed {
    logic [7:0]          byte_value;
    logic [OFFSET_W-1:0] start_offset;
    logic [7:0]          run_length;
    logic                plane_done;
    logic                channel_done;
    logic                overrun;
  } res_t;

endpackage

// ===== rtl/core/rlapd_cfg_regs.sv =====
// rlapd_cfg_regs: configuration registers with range saturation on write
// depends on rlapd_pkg
`timescale 1ns / 1ps

module rlapd_cfg_regs #(
  parameter int MAX_LINE_PIXELS = 8192
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [rlapd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output rlapd_pkg::cfg_t                 cfg
);
  import rlapd_pkg::*;

  localparam logic [16:0] MAX_PPL = 17'(MAX_LINE_PIXELS);

  logic [POS_W-1:0]    ppl_r, ppl_nxt;
  logic [4:0]          ch_r, ch_nxt;
  logic [2:0]          bps_r, bps_nxt;
  logic                le_r, le_nxt;
  logic [STRIDE_W-1:0] stride_r, stride_nxt;
  logic [POS_W-1:0]    ppl_sat;
  logic [4:0]          ch_sat;
  logic [2:0]          bps_sat;

  // saturate written values into legal ranges
  always_comb begin
    ppl_sat = cfg_wdata[POS_W-1:0];
    if (ppl_sat == '0) begin
      ppl_sat = POS_W'(1);
    end else if ({3'b000, ppl_sat} > MAX_PPL) begin
      ppl_sat = MAX_PPL[POS_W-1:0];
    end
    ch_sat = cfg_wdata[4:0];
    if (ch_sat == 5'd0) begin
      ch_sat = 5'd1;
    end else if (ch_sat > 5'd16) begin
      ch_sat = 5'd16;
    end
    bps_sat = cfg_wdata[2:0];
    if (bps_sat == 3'd0) begin
      bps_sat = 3'd1;
    end else if (bps_sat > 3'd4) begin
      bps_sat = 3'd4;
    end
  end

  // register write decode
  always_comb begin
    ppl_nxt = ppl_r;
    ch_nxt  = ch_r;
    bps_nxt = bps_r;
    le_nxt  = le_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_PIXELS_PER_LINE:    ppl_nxt = ppl_sat;
        REG_CHANNEL_COUNT:      ch_nxt  = ch_sat;
        REG_BYTES_PER_SAMPLE:   bps_nxt = bps_sat;
        REG_HOST_LITTLE_ENDIAN: le_nxt  = cfg_wdata[0];
        default:                ppl_nxt = ppl_r;
      endcase
    end
    // byte stride between samples of one channel
    stride_nxt = {2'b00, ch_r} * {4'b0000, bps_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppl_r    <= POS_W'(1);
      ch_r     <= 5'd1;
      bps_r    <= 3'd1;
      le_r     <= 1'b1;
      stride_r <= STRIDE_W'(1);
    end else begin
      ppl_r    <= ppl_nxt;
      ch_r     <= ch_nxt;
      bps_r    <= bps_nxt;
      le_r     <= le_nxt;
      stride_r <= stride_nxt;
    end
  end

  assign cfg.pixels_per_line    = ppl_r;
  assign cfg.bytes_per_sample   = bps_r;
  assign cfg.host_little_endian = le_r;
  assign cfg.stride             = stride_r;

endmodule

// ===== rtl/core/rlapd_parse.sv =====
// rlapd_parse: packet parse state and per-byte run placement
// depends on rlapd_pkg
`timescale 1ns / 1ps

module rlapd_parse (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [7:0]      data_byte,
  input  logic            start_channel,
  input  rlapd_pkg::cfg_t cfg,
  output logic            has_res,
  output rlapd_pkg::res_t res
);
  import rlapd_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       run_left_r, run_left_nxt;
  logic [7:0]       repeat_len_r, repeat_len_nxt;
  logic [1:0]       plane_r, plane_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  phase_t           phase_e;
  logic [7:0]       run_left_e;
  logic [7:0]       repeat_len_e;
  logic [1:0]       plane_e;
  logic [POS_W-1:0] pos_e;

  logic [1:0]       last_pl;
  logic [1:0]       pl;
  logic [1:0]       sub;
  logic [POS_W-1:0] left;
  logic [7:0]       want;
  logic [7:0]       len;
  logic             pdone;
  logic             cdone;
  logic [20:0]      prod;
  logic [7:0]       rl_dec;

  // channel start returns the parser to its initial state
  always_comb begin
    if (start_channel) begin
      phase_e      = PH_COUNT;
      run_left_e   = '0;
      repeat_len_e = '0;
      plane_e      = '0;
      pos_e        = '0;
    end else begin
      phase_e      = phase_r;
      run_left_e   = run_left_r;
      repeat_len_e = repeat_len_r;
      plane_e      = plane_r;
      pos_e        = pos_r;
    end
  end

  // run placement: clip to line end, offset in interleaved buffer
  always_comb begin
    last_pl = 2'(cfg.bytes_per_sample - 3'd1);
    pl      = (plane_e <= last_pl) ? plane_e : last_pl;
    left    = (pos_e < cfg.pixels_per_line) ? (cfg.pixels_per_line - pos_e) : POS_W'(1);
    want    = (phase_e == PH_REPEAT) ? repeat_len_e : 8'd1;
    len     = ({6'b0, want} < left) ? want : left[7:0];
    pdone   = ({6'b0, len} == left);
    cdone   = pdone && (pl == last_pl);
    sub     = cfg.host_little_endian ? (last_pl - pl) : pl;
    prod    = 21'(pos_e) * 21'(cfg.stride);
    rl_dec  = run_left_e - 8'd1;
  end

  // next state and result
  always_comb begin
    phase_nxt      = phase_e;
    run_left_nxt   = run_left_e;
    repeat_len_nxt = repeat_len_e;
    plane_nxt      = plane_e;
    pos_nxt        = pos_e;
    has_res        = 1'b0;

    res.byte_value   = data_byte;
    res.start_offset = prod[OFFSET_W-1:0] + OFFSET_W'(sub);
    res.run_length   = len;
    res.plane_done   = pdone;
    res.channel_done = cdone;
    res.overrun      = ({6'b0, want} > left);

    case (phase_e)
      PH_COUNT: begin
        if (!data_byte[7]) begin
          repeat_len_nxt = data_byte + 8'd1;
          phase_nxt      = PH_REPEAT;
        end else begin
          run_left_nxt = 8'd0 - data_byte;
          phase_nxt    = PH_LITERAL;
        end
      end
      PH_REPEAT: begin
        has_res   = 1'b1;
        phase_nxt = PH_COUNT;
      end
      PH_LITERAL: begin
        has_res      = 1'b1;
        run_left_nxt = rl_dec;
        if (pdone && (rl_dec != 8'd0)) begin
          res.overrun = 1'b1;
        end
        if (rl_dec == 8'd0) begin
          phase_nxt = PH_COUNT;
        end else if (pdone) begin
          phase_nxt = PH_DROP;
        end
      end
      PH_DROP: begin
        run_left_nxt = rl_dec;
        if (rl_dec == 8'd0) begin
          phase_nxt = PH_COUNT;
        end
      end
      default: phase_nxt = PH_COUNT;
    endcase

    // advance position and plane on every emitted run
    if (has_res) begin
      if (pdone) begin
        pos_nxt   = '0;
        plane_nxt = cdone ? 2'd0 : (pl + 2'd1);
      end else begin
        pos_nxt = pos_e + POS_W'(len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_COUNT;
      run_left_r   <= '0;
      repeat_len_r <= '0;
      plane_r      <= '0;
      pos_r        <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      run_left_r   <= run_left_nxt;
      repeat_len_r <= repeat_len_nxt;
      plane_r      <= plane_nxt;
      pos_r        <= pos_nxt;
    end
  end

endmodule

// ===== rtl/core/rla_rle_plane_decoder_top.sv =====
// rla_rle_plane_decoder_top: byte-planar rla run-length decoder
// an input beat passes through the input register and then the result register to become a result beat
// throughput: one compressed byte per cycle while out_stall does not hold a pending result beat
// a byte with no result (count byte, dropped literal) frees its slot at once
// reset (rst_n low, synchronous) clears both stages, parse state and config to defaults
// depends on rlapd_pkg, rlapd_cfg_regs, rlapd_parse
`timescale 1ns / 1ps

module rla_rle_plane_decoder_top #(
  parameter int MAX_LINE_PIXELS = 8192
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [rlapd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_start_channel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_byte_value,
  output logic [rlapd_pkg::OFFSET_W-1:0]   out_start_offset,
  output logic [7:0]                       out_run_length,
  output logic                             out_plane_done,
  output logic                             out_channel_done,
  output logic                             out_overrun
);
  import rlapd_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_r;
  logic has_res;

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_start_r;
  logic       out_vld_r, out_vld_nxt;
  logic       in_take;
  logic       fire;

  rlapd_cfg_regs #(
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rlapd_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .data_byte     (in_byte_r),
    .start_channel (in_start_r),
    .cfg           (cfg),
    .has_res       (has_res),
    .res           (res)
  );

  // handshake: held byte is processed when the result slot is free or draining
  always_comb begin
    fire        = in_vld_r && (!out_vld_r || !out_stall);
    in_stall    = in_vld_r && !fire;
    in_take     = in_valid && !in_stall;
    in_vld_nxt  = in_take || (in_vld_r && !fire);
    out_vld_nxt = fire ? has_res : (out_vld_r && out_stall);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // input beat register
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r  <= in_data_byte;
      in_start_r <= in_start_channel;
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (fire && has_res) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_byte_value   = res_r.byte_value;
  assign out_start_offset = res_r.start_offset;
  assign out_run_length   = res_r.run_length;
  assign out_plane_done   = res_r.plane_done;
  assign out_channel_done = res_r.channel_done;
  assign out_overrun      = res_r.overrun;

endmodule

// ===== tb/rla_rle_plane_decoder_top_test.sv =====
// rla_rle_plane_decoder_top_test: self-checking bench for the rla plane decoder
// predicts every decoded run from its own copy of the parse state and checks results in order
// depends on rlapd_pkg and rla_rle_plane_decoder_top
`timescale 1ns / 1ps

module rla_rle_plane_decoder_top_test;
  import rlapd_pkg::*;

  localparam int MAX_LINE     = 8192;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = REG_PIXELS_PER_LINE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_data_byte = '0;
  logic                  in_start_channel = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_byte_value;
  logic [OFFSET_W-1:0]   out_start_offset;
  logic [7:0]            out_run_length;
  logic                  out_plane_done;
  logic                  out_channel_done;
  logic                  out_overrun;

  rla_rle_plane_decoder_top #(.MAX_LINE_PIXELS(MAX_LINE)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_start_channel (in_start_channel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_value   (out_byte_value),
    .out_start_offset (out_start_offset),
    .out_run_length   (out_run_length),
    .out_plane_done   (out_plane_done),
    .out_channel_done (out_channel_done),
    .out_overrun      (out_overrun)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the registers, raw as written
  logic [13:0] r_ppl = 14'd1;
  logic [4:0]  r_ch = 5'd1;
  logic [2:0]  r_bps = 3'd1;
  logic        r_hle = 1'b1;

  // shadow parse state
  phase_t      m_phase = PH_COUNT;
  logic [7:0]  m_run_left = '0;
  logic [7:0]  m_repeat_len = '0;
  logic [1:0]  m_plane = '0;
  logic [13:0] m_pos = '0;

  res_t expected_runs[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_sent = 0;
  int runs_checked = 0;
  int settings_used = 0;
  int errors = 0;
  int cycle_count = 0;
  int chunk_end = 0;

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // place one run of want writes in the interleaved buffer and advance the line
  function automatic res_t place_run(input logic [7:0] value, input int want,
                                     output bit line_end);
    res_t r;
    int ppl, ch, bps, pl, left, len, sub, off;
    ppl = clamp_int(int'(r_ppl), 1, MAX_LINE);
    ch = clamp_int(int'(r_ch), 1, 16);
    bps = clamp_int(int'(r_bps), 1, 4);
    pl = (m_plane < bps) ? int'(m_plane) : bps - 1;
    // a line that shrank under the current position ends on the next run
    left = (m_pos < ppl) ? ppl - int'(m_pos) : 1;
    len = (want < left) ? want : left;
    sub = r_hle ? bps - 1 - pl : pl;
    off = int'(m_pos) * ch * bps + sub;
    r.byte_value = value;
    r.start_offset = OFFSET_W'(off);
    r.run_length = 8'(len);
    r.plane_done = (len == left);
    r.channel_done = r.plane_done && (pl == bps - 1);
    r.overrun = (want > left);
    if (r.plane_done) begin
      m_pos = '0;
      m_plane = r.channel_done ? 2'd0 : 2'(pl + 1);
    end else begin
      m_pos = 14'(int'(m_pos) + len);
    end
    line_end = r.plane_done;
    return r;
  endfunction

  // advance the shadow parser by one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic sc);
    res_t r;
    bit line_end;
    if (sc) begin
      m_phase = PH_COUNT;
      m_run_left = '0;
      m_repeat_len = '0;
      m_plane = '0;
      m_pos = '0;
    end
    case (m_phase)
      PH_COUNT: begin
        if (!b[7]) begin
          m_repeat_len = b + 8'd1;
          m_phase = PH_REPEAT;
        end else begin
          // magnitude of the negative count
          m_run_left = ~b + 8'd1;
          m_phase = PH_LITERAL;
        end
      end
      PH_REPEAT: begin
        r = place_run(b, int'(m_repeat_len), line_end);
        expected_runs.push_back(r);
        m_phase = PH_COUNT;
      end
      PH_LITERAL: begin
        m_run_left = m_run_left - 8'd1;
        r = place_run(b, 1, line_end);
        if (line_end && m_run_left != 0) r.overrun = 1'b1;
        expected_runs.push_back(r);
        if (m_run_left == 0) m_phase = PH_COUNT;
        else if (line_end) m_phase = PH_DROP;
      end
      default: begin
        m_run_left = m_run_left - 8'd1;
        if (m_run_left == 0) m_phase = PH_COUNT;
      end
    endcase
  endtask

  // send one compressed beat, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b, input logic sc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_start_channel <= sc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b, sc);
    bytes_sent++;
  endtask

  // stop sending and let every expected run come out
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_PIXELS_PER_LINE:  r_ppl = val[13:0];
      REG_CHANNEL_COUNT:    r_ch = val[4:0];
      REG_BYTES_PER_SAMPLE: r_bps = val[2:0];
      default:              r_hle = val[0];
    endcase
  endtask

  task automatic write_config(input logic [13:0] ppl, input logic [4:0] ch,
                              input logic [2:0] bps, input logic hle);
    write_reg(REG_PIXELS_PER_LINE, ppl);
    write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'(ch));
    write_reg(REG_BYTES_PER_SAMPLE, CFG_DATA_W'(bps));
    write_reg(REG_HOST_LITTLE_ENDIAN, CFG_DATA_W'(hle));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // one channel scanline of random packets, mostly well framed
  task automatic send_channel(input bit fresh);
    int ppl, bps, left, n, k;
    bit first;
    ppl = clamp_int(int'(r_ppl), 1, MAX_LINE);
    bps = clamp_int(int'(r_bps), 1, 4);
    first = fresh;
    for (int p = 0; p < bps; p++) begin
      left = ppl;
      while (left > 0 && bytes_sent < chunk_end) begin
        k = $urandom_range(99);
        if (k < 4) begin
          // stray byte that knocks the packet framing off
          send_byte(8'($urandom), first);
        end else if (k < 6) begin
          // abandon the line, the next channel restarts the parser
          return;
        end else begin
          if (k < 16) n = left + $urandom_range(1, 6);
          else n = $urandom_range(1, (left < 128) ? left : 128);
          if (n > 128) n = 128;
          if ($urandom_range(1)) begin
            send_byte(8'(n - 1), first);
            send_byte(8'($urandom), 1'b0);
          end else begin
            send_byte(8'(256 - n), first);
            for (int i = 0; i < n; i++) send_byte(8'($urandom), 1'b0);
          end
          left -= n;
        end
        first = 1'b0;
      end
    end
  endtask

  // reset defaults, then every packet kind on a short two-plane line
  task automatic test_packets();
    send_byte(8'h00, 1'b1); send_byte(8'hFF, 1'b0);
    send_byte(8'h02, 1'b0); send_byte(8'h5A, 1'b0);
    wait_quiet();
    write_config(14'd4, 5'd3, 3'd2, 1'b1);
    send_byte(8'h01, 1'b1); send_byte(8'hAA, 1'b0);
    send_byte(8'hFE, 1'b0); send_byte(8'h11, 1'b0); send_byte(8'h22, 1'b0);
    // longest repeat runs past the line end
    send_byte(8'h7F, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hFD, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h33, 1'b0);
    // longest literal packet runs past the line end, the rest is dropped
    send_byte(8'h80, 1'b0); send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b0); send_byte(8'h66, 1'b0); send_byte(8'h77, 1'b0);
    send_byte(8'h00, 1'b1); send_byte(8'h99, 1'b0);
    // channel restart in the middle of a literal packet
    send_byte(8'hFF, 1'b0); send_byte(8'h12, 1'b1); send_byte(8'hEE, 1'b0);
    wait_quiet();
  endtask

  // line and plane count shrink while the parser is in mid line
  task automatic test_shrink_mid_line();
    write_config(14'd8, 5'd2, 3'd4, 1'b0);
    send_byte(8'h07, 1'b1); send_byte(8'h01, 1'b0);
    send_byte(8'h07, 1'b0); send_byte(8'h02, 1'b0);
    send_byte(8'h04, 1'b0); send_byte(8'h03, 1'b0);
    wait_quiet();
    write_config(14'd3, 5'd2, 3'd2, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h04, 1'b0);
    send_byte(8'hFC, 1'b0); send_byte(8'h05, 1'b0); send_byte(8'h06, 1'b0);
    send_byte(8'h07, 1'b0); send_byte(8'h08, 1'b0);
    wait_quiet();
  endtask

  // saturated registers: full 8192 sample line up to the highest offset, then all minimums
  task automatic test_full_width_line();
    write_config(14'h3FFF, 5'd31, 3'd7, 1'b1);
    send_byte(8'h7F, 1'b1); send_byte(8'($urandom), 1'b0);
    repeat (62) begin
      send_byte(8'h7F, 1'b0); send_byte(8'($urandom), 1'b0);
    end
    send_byte(8'h7E, 1'b0); send_byte(8'($urandom), 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'($urandom), 1'b0);
    send_byte(8'h7F, 1'b0); send_byte(8'($urandom), 1'b0);
    wait_quiet();
    write_config(14'd0, 5'd0, 3'd0, 1'b0);
    send_byte(8'h05, 1'b1); send_byte(8'hAB, 1'b0);
    send_byte(8'hFE, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'h02, 1'b0);
    wait_quiet();
  endtask

  // random settings, each followed by a burst of random scanlines
  task automatic test_random(input int count);
    int stop_at, k;
    logic [13:0] ppl;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      wait_quiet();
      k = $urandom_range(99);
      if (k < 60) ppl = 14'($urandom_range(1, 10));
      else if (k < 85) ppl = 14'($urandom_range(11, 300));
      else if (k < 92) ppl = 14'd0;
      else ppl = 14'($urandom_range(8100, 16383));
      write_config(ppl, 5'($urandom_range(31)), 3'($urandom_range(7)), 1'($urandom_range(1)));
      chunk_end = bytes_sent + $urandom_range(30, 80);
      if (chunk_end > stop_at) chunk_end = stop_at;
      // sometimes carry on with the old line under the new setting
      send_channel($urandom_range(3) != 0);
      while (bytes_sent < chunk_end) send_channel(1'b1);
    end
  endtask

  task automatic check_field(input string field, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
    end
  endtask

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // compare each result beat with the oldest expected run
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_runs.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual byte %0d offset %0d",
                 $time, out_byte_value, out_start_offset);
      end else begin
        want = expected_runs.pop_front();
        check_field("byte_value", 32'(want.byte_value), 32'(out_byte_value));
        check_field("start_offset", 32'(want.start_offset), 32'(out_start_offset));
        check_field("run_length", 32'(want.run_length), 32'(out_run_length));
        check_field("plane_done", 32'(want.plane_done), 32'(out_plane_done));
        check_field("channel_done", 32'(want.channel_done), 32'(out_channel_done));
        check_field("overrun", 32'(want.overrun), 32'(out_overrun));
        runs_checked++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d runs still expected",
               cycle_count, expected_runs.size());
      $display("Verification failed");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 14;
    recv_idle_pct = 73;
    test_packets();
    test_shrink_mid_line();
    test_full_width_line();
    test_random(150);
    send_idle_pct = 73;
    recv_idle_pct = 14;
    test_random(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(150);
    wait_quiet();
    $display("sent %0d compressed bytes under %0d register settings", bytes_sent, settings_used);
    $display("checked %0d decoded runs, %0d mismatches", runs_checked, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
